[rtl/wlsg_pkg.sv]
package wlsg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WSHIFT      = 62 - 2 * FRAC_BITS;
    localparam int GSHIFT      = 2 * FRAC_BITS;
    localparam int VAL_W       = 32;
    localparam int DELTA_W     = 33;
    localparam int INV_W       = 48;
    localparam int ACC_W       = 64;
    localparam int W_BITS      = 63;
    localparam int DIV_CW      = 6;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int WIDE_W      = 128;
    localparam int EPS_W       = 16;
    localparam int IN_W        = 448;
    localparam int OUT_W       = 144;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic [2:0] INV_XX = 3'd0;
    localparam logic [2:0] INV_XY = 3'd1;
    localparam logic [2:0] INV_XZ = 3'd2;
    localparam logic [2:0] INV_YY = 3'd3;
    localparam logic [2:0] INV_YZ = 3'd4;
    localparam logic [2:0] INV_ZZ = 3'd5;

    typedef struct packed {
        logic [2:0][VAL_W-1:0] mag_r;
        logic [2:0]            sgn_r;
        logic [DELTA_W-1:0]    mag_delta;
        logic                  sgn_delta;
        logic [5:0][INV_W-1:0] mag_inv;
        logic [5:0]            sgn_inv;
        logic                  last;
    } wlsg_item_t;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_SQ_MUL = 14'b00000000000010,
        ST_SQ_ACC = 14'b00000000000100,
        ST_DSTART = 14'b00000000001000,
        ST_DWAIT  = 14'b00000000010000,
        ST_M_MUL  = 14'b00000000100000,
        ST_M_ACC  = 14'b00000001000000,
        ST_PP_MUL = 14'b00000010000000,
        ST_PP_ACC = 14'b00000100000000,
        ST_TERM   = 14'b00001000000000,
        ST_G_MUL  = 14'b00010000000000,
        ST_G_ACC  = 14'b00100000000000,
        ST_G_SUM  = 14'b01000000000000,
        ST_G_FIN  = 14'b10000000000000
    } wlsg_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wlsg_qstat_t;

    // entry of the symmetric inverse for row k, column j
    function automatic logic [2:0] inv_sel(input logic [1:0] k, input logic [1:0] j);
        logic [2:0] idx;
        case ({k, j})
            4'b0000: idx = INV_XX;
            4'b0001: idx = INV_XY;
            4'b0010: idx = INV_XZ;
            4'b0100: idx = INV_XY;
            4'b0101: idx = INV_YY;
            4'b0110: idx = INV_YZ;
            4'b1000: idx = INV_XZ;
            4'b1001: idx = INV_YZ;
            4'b1010: idx = INV_ZZ;
            default: idx = INV_XX;
        endcase
        return idx;
    endfunction

endpackage

[rtl/wlsg_front.sv]
module wlsg_front
    import wlsg_pkg::*;
(
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            s_tlast,
    input  wlsg_qstat_t     qstat,
    output logic            push,
    output wlsg_item_t      item
);

    logic [VAL_W-1:0]   rv;
    logic [VAL_W-1:0]   other_v;
    logic [VAL_W-1:0]   center_v;
    logic [DELTA_W-1:0] delta;
    logic [INV_W-1:0]   iv;

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;

    assign other_v  = s_tdata[127:96];
    assign center_v = s_tdata[159:128];
    assign delta    = {other_v[VAL_W-1], other_v} - {center_v[VAL_W-1], center_v};

    always_comb
    begin
        item = '0;
        for (int i = 0; i < 3; i++)
        begin
            rv = s_tdata[VAL_W*i +: VAL_W];
            item.sgn_r[i] = rv[VAL_W-1];
            item.mag_r[i] = rv[VAL_W-1] ? (~rv + 32'd1) : rv;
        end
        item.sgn_delta = delta[DELTA_W-1];
        item.mag_delta = delta[DELTA_W-1] ? (~delta + 33'd1) : delta;
        for (int i = 0; i < 6; i++)
        begin
            iv = s_tdata[160 + INV_W*i +: INV_W];
            item.sgn_inv[i] = iv[INV_W-1];
            item.mag_inv[i] = iv[INV_W-1] ? (~iv + 48'd1) : iv;
        end
        item.last = s_tlast;
    end

endmodule

[rtl/wlsg_queue.sv]
module wlsg_queue
    import wlsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wlsg_item_t  push_item,
    input  logic        pop,
    output wlsg_item_t  head,
    output wlsg_qstat_t qstat
);

    wlsg_item_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_next;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/wlsg_div.sv]
module wlsg_div
    import wlsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  divisor,
    output logic              done,
    output logic [W_BITS-1:0] quotient
);

    // restoring division of 2^(W_BITS-1) by divisor, one quotient bit a cycle
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [ACC_W:0]    rem_reg;
    logic [W_BITS-1:0] quo_reg;
    logic [ACC_W-1:0]  div_reg;
    logic              busy_next;
    logic              done_next;
    logic [DIV_CW-1:0] cnt_next;
    logic [ACC_W:0]    rem_next;
    logic [W_BITS-1:0] quo_next;
    logic [ACC_W:0]    r_sh;
    logic              nbit;
    logic              ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    assign nbit = (cnt_reg == DIV_CW'(W_BITS - 1));
    assign r_sh = {rem_reg[ACC_W-1:0], nbit};
    assign ge   = (r_sh >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(W_BITS - 1);
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (r_sh - {1'b0, div_reg}) : r_sh;
            quo_next = {quo_reg[W_BITS-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

endmodule

[rtl/wlsg_back.sv]
module wlsg_back
    import wlsg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [EPS_W-1:0] cfg_wdata,
    input  wlsg_qstat_t      qstat,
    input  wlsg_item_t       head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    wlsg_state_t           state_reg, state_next;
    wlsg_item_t            item_reg, item_next;
    logic [1:0]            axis_reg, axis_next;
    logic [1:0]            j_reg, j_next;
    logic [1:0]            pp_reg, pp_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [WIDE_W-1:0]     acc_reg, acc_next;
    logic [WIDE_W-1:0]     gacc_reg, gacc_next;
    logic [ACC_W-1:0]      d2_reg, d2_next;
    logic [W_BITS-1:0]     w_reg, w_next;
    logic [W_BITS-1:0]     m_reg, m_next;
    logic [2:0][ACC_W-1:0] sum_reg, sum_next;
    logic [2:0][INV_W-1:0] grad_reg, grad_next;
    logic [EPS_W-1:0]      eps_reg, eps_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic                  div_start;
    logic                  div_done;
    logic [ACC_W-1:0]      divisor;
    logic [W_BITS-1:0]     quotient;

    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [6:0]            shamt;
    logic [WIDE_W-1:0]     addend;
    logic [ACC_W-1:0]      sum_sel;
    logic [ACC_W-1:0]      sum_mag;
    logic [2:0]            inv_idx;
    logic [INV_W-1:0]      inv_mag;
    logic                  g_neg;
    logic [WIDE_W-1:0]     tsh;
    logic [W_BITS-1:0]     tmag;
    logic [ACC_W-1:0]      term_mag;
    logic [ACC_W-1:0]      term_val;
    logic [ACC_W-1:0]      sum_add;
    logic [ACC_W-1:0]      sum_sat;
    logic signed [WIDE_W-1:0] gsh;
    logic [INV_W-1:0]      grad_sat;
    logic                  out_load;

    wlsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign divisor  = (d2_reg == '0) ? ACC_W'(1) : d2_reg;
    assign out_load = (state_reg == ST_IDLE) && 1'b0;

    // operands of the one shared multiplier
    assign sum_sel = sum_reg[j_reg];
    assign sum_mag = sum_sel[ACC_W-1] ? (~sum_sel + 64'd1) : sum_sel;
    assign inv_idx = inv_sel(axis_reg, j_reg);
    assign inv_mag = item_reg.mag_inv[inv_idx];
    assign g_neg   = item_reg.sgn_inv[inv_idx] ^ sum_sel[ACC_W-1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = {1'b0, item_reg.mag_r[axis_reg]};
                mul_b = {1'b0, item_reg.mag_r[axis_reg]};
            end
            ST_M_MUL:
            begin
                mul_a = item_reg.mag_delta;
                mul_b = {1'b0, item_reg.mag_r[axis_reg]};
            end
            ST_PP_MUL:
            begin
                mul_a = pp_reg[1] ? {2'b0, m_reg[62:32]} : {1'b0, m_reg[31:0]};
                mul_b = pp_reg[0] ? {2'b0, w_reg[62:32]} : {1'b0, w_reg[31:0]};
            end
            ST_G_MUL:
            begin
                mul_a = pp_reg[1] ? {9'b0, inv_mag[47:24]} : {9'b0, inv_mag[23:0]};
                mul_b = pp_reg[0] ? {1'b0, sum_mag[63:32]} : {1'b0, sum_mag[31:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case ({state_reg == ST_G_ACC, pp_reg})
            3'b001:  shamt = 7'd32;
            3'b010:  shamt = 7'd32;
            3'b011:  shamt = 7'd64;
            3'b101:  shamt = 7'd32;
            3'b110:  shamt = 7'd24;
            3'b111:  shamt = 7'd56;
            default: shamt = 7'd0;
        endcase
    end

    assign addend = WIDE_W'(prod_reg) << shamt;

    // weighted term: truncate, saturate the magnitude, then sign it
    assign tsh      = acc_reg >> WSHIFT;
    assign tmag     = (|tsh[WIDE_W-1:W_BITS]) ? {W_BITS{1'b1}} : tsh[W_BITS-1:0];
    assign term_mag = {1'b0, tmag};
    assign term_val = (item_reg.sgn_delta ^ item_reg.sgn_r[axis_reg]) ?
                      (~term_mag + 64'd1) : term_mag;
    assign sum_add  = sum_reg[axis_reg] + term_val;

    always_comb
    begin
        if (sum_reg[axis_reg][ACC_W-1] == term_val[ACC_W-1] &&
            sum_add[ACC_W-1] != term_val[ACC_W-1])
        begin
            sum_sat = sum_reg[axis_reg][ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} :
                                                   {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_add;
        end
    end

    assign gsh = $signed(gacc_reg) >>> GSHIFT;

    always_comb
    begin
        if ((&gsh[WIDE_W-1:INV_W-1]) || !(|gsh[WIDE_W-1:INV_W-1]))
        begin
            grad_sat = gsh[INV_W-1:0];
        end
        else
        begin
            grad_sat = gsh[WIDE_W-1] ? {1'b1, {(INV_W-1){1'b0}}} : {1'b0, {(INV_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        axis_next      = axis_reg;
        j_next         = j_reg;
        pp_next        = pp_reg;
        prod_next      = mul_a * mul_b;
        acc_next       = acc_reg;
        gacc_next      = gacc_reg;
        d2_next        = d2_reg;
        w_next         = w_reg;
        m_next         = m_reg;
        sum_next       = sum_reg;
        grad_next      = grad_reg;
        eps_next       = cfg_we ? cfg_wdata : eps_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    d2_next    = ACC_W'(eps_reg);
                    axis_next  = 2'd0;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                d2_next = d2_reg + prod_reg[ACC_W-1:0];
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_DSTART;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    w_next     = quotient;
                    state_next = ST_M_MUL;
                end
            end
            ST_M_MUL:
            begin
                state_next = ST_M_ACC;
            end
            ST_M_ACC:
            begin
                m_next     = prod_reg[W_BITS-1:0];
                acc_next   = '0;
                pp_next    = 2'd0;
                state_next = ST_PP_MUL;
            end
            ST_PP_MUL:
            begin
                state_next = ST_PP_ACC;
            end
            ST_PP_ACC:
            begin
                acc_next   = acc_reg + addend;
                pp_next    = pp_reg + 2'd1;
                state_next = (pp_reg == 2'd3) ? ST_TERM : ST_PP_MUL;
            end
            ST_TERM:
            begin
                sum_next[axis_reg] = sum_sat;
                if (axis_reg == 2'd2)
                begin
                    axis_next = 2'd0;
                    if (item_reg.last)
                    begin
                        j_next     = 2'd0;
                        pp_next    = 2'd0;
                        acc_next   = '0;
                        gacc_next  = '0;
                        state_next = ST_G_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_M_MUL;
                end
            end
            ST_G_MUL:
            begin
                state_next = ST_G_ACC;
            end
            ST_G_ACC:
            begin
                acc_next   = acc_reg + addend;
                pp_next    = pp_reg + 2'd1;
                state_next = (pp_reg == 2'd3) ? ST_G_SUM : ST_G_MUL;
            end
            ST_G_SUM:
            begin
                gacc_next = gacc_reg + (g_neg ? (~acc_reg + 128'd1) : acc_reg);
                acc_next  = '0;
                pp_next   = 2'd0;
                if (j_reg == 2'd2)
                begin
                    j_next     = 2'd0;
                    state_next = ST_G_FIN;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = ST_G_MUL;
                end
            end
            ST_G_FIN:
            begin
                // store each earlier axis's gradient; hold the last until the output register is free
                if (axis_reg == 2'd2)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_next  = {grad_sat, grad_reg[1], grad_reg[0]};
                        out_valid_next = 1'b1;
                        sum_next       = '0;
                        gacc_next      = '0;
                        axis_next      = 2'd0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    grad_next[axis_reg] = grad_sat;
                    gacc_next           = '0;
                    axis_next           = axis_reg + 2'd1;
                    state_next          = ST_G_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            j_reg         <= '0;
            pp_reg        <= '0;
            sum_reg       <= '0;
            eps_reg       <= EPS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            j_reg         <= j_next;
            pp_reg        <= pp_next;
            sum_reg       <= sum_next;
            eps_reg       <= eps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        gacc_reg     <= gacc_next;
        d2_reg       <= d2_next;
        w_reg        <= w_next;
        m_reg        <= m_next;
        grad_reg     <= grad_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_G_FIN && axis_reg == 2'd2))
        else $error("result raised outside the final gradient step");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_FIN && axis_reg == 2'd2 && (!out_valid_reg || m_tready))
        |=> (sum_reg == '0 && out_valid_reg))
        else $error("accumulators not cleared with the result");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("divider finished while not awaited");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!qstat.empty && !out_load))
        else $error("pop from an empty queue");
`endif

endmodule

[rtl/weighted_least_squares_gradient_top.sv]
// Channel  Dir  Data                                                          Marker
// s_*      in   tdata: off_x off_y off_z other_value center_value
//               inv_xx inv_xy inv_xz inv_yy inv_yz inv_zz (448 bits)          tlast = last
// m_*      out  tdata: grad_x grad_y grad_z (144 bits)                        none
// cfg_*    in   cfg_wdata: small_eps (16 bits), written when cfg_we is high   none
//
// An item's work is paced by the 63-step weight divider and the one shared 33x33
// multiplier; an item with tlast also runs the inverse-matrix products. A two-entry
// queue lets intake run ahead of the datapath.
// rst_n clears the per-axis sums, the queue and the output valid; small_eps resets to 1.
// A result waiting on m_tready holds the datapath in its final gradient step; intake
// goes on until the queue is full, then s_tready drops.
module weighted_least_squares_gradient_top
    import wlsg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [EPS_W-1:0] cfg_wdata,   // small_eps
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,     // off_x, off_y, off_z, other_value, center_value,
                                          // inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata      // grad_x, grad_y, grad_z
);

    wlsg_qstat_t qstat;
    wlsg_item_t  push_item;
    wlsg_item_t  head;
    logic        push;
    logic        pop;

    wlsg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (push),
        .item     (push_item)
    );

    wlsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    wlsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
